>>> src/wjd_pkg.sv
// Shared constants and command type for the weighted Jaccard distance block.
package wjd_pkg;

  localparam int WGT_W  = 16;
  localparam int ACC_W  = 26;
  localparam int CNT_W  = 11;
  localparam int DIST_W = 17;
  localparam int SUM_W  = ACC_W + 1;
  localparam int REM_W  = ACC_W + 2;

  localparam int IN_DATA_W  = 2 * WGT_W;
  localparam int OUT_BITS   = DIST_W + 2 * ACC_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  localparam logic [ACC_W-1:0]  ACC_MAX = {ACC_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
  localparam logic [DIST_W-1:0] Q_ONE   = DIST_W'(65536);

  // one quotient bit per step: the integer bit, then 16 fraction bits
  localparam int DIV_STEPS = DIST_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic acc_en;
    logic snap;
    logic div_step;
    logic div_first;
    logic out_load;
  } cmd_t;

endpackage

>>> src/wjd_ctrl.sv
// Controller: accumulate, divide and result hand-off sequencing.
module wjd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wjd_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_ACCUM  = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_HOLD   = 3'b100
  } state_t;

  state_t                       state, state_next;
  logic [wjd_pkg::STEP_W-1:0]   step_cnt, step_cnt_next;
  logic                         out_valid_next;
  logic                         fire;

  assign in_ready = (state == ST_ACCUM);
  assign fire     = in_valid & in_ready;

  always_comb begin
    state_next     = state;
    step_cnt_next  = step_cnt;
    cmd            = '0;
    unique case (state)
      ST_ACCUM: begin
        cmd.acc_en = fire;
        cmd.snap   = fire & in_last;
        if (fire && in_last) begin
          state_next    = ST_DIVIDE;
          step_cnt_next = '0;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step_cnt == '0);
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == wjd_pkg::STEP_W'(wjd_pkg::DIV_STEPS - 1)) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> src/wjd_dpath.sv
// Datapath: weight accumulators, column count, serial divider, result register.
module wjd_dpath #(
  parameter int MAX_COLUMNS = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wjd_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic [wjd_pkg::IN_DATA_W-1:0]      in_data,
  input  wjd_pkg::cmd_t                      cmd,
  output logic [wjd_pkg::OUT_DATA_W-1:0]     out_data,
  output logic [wjd_pkg::OUT_USER_W-1:0]     out_user
);

  localparam logic [wjd_pkg::WGT_W-1:0] WMASK =
    (WEIGHT_BITS >= wjd_pkg::WGT_W) ? {wjd_pkg::WGT_W{1'b1}}
                                    : wjd_pkg::WGT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam logic [wjd_pkg::CNT_W-1:0] NUM_COLUMNS_RST = wjd_pkg::CNT_W'(MAX_COLUMNS);

  logic [wjd_pkg::CNT_W-1:0]  num_columns;
  logic [wjd_pkg::ACC_W-1:0]  intersect_acc, distinct_acc;
  logic [wjd_pkg::CNT_W-1:0]  column_count;

  logic [wjd_pkg::WGT_W-1:0]  wa, wb;
  logic                       hit_i, hit_d;
  logic [wjd_pkg::SUM_W-1:0]  sum_i, sum_d;
  logic [wjd_pkg::ACC_W-1:0]  i_new, d_new;
  logic [wjd_pkg::CNT_W-1:0]  cnt_new;

  logic [wjd_pkg::ACC_W-1:0]  res_i, res_d;
  logic                       res_empty, res_err;
  logic [wjd_pkg::SUM_W-1:0]  div_den;
  logic [wjd_pkg::REM_W-1:0]  div_rem, rem_sh, rem_sub;
  logic [wjd_pkg::DIST_W-1:0] div_q;
  logic                       q_bit;

  assign wa    = in_data[wjd_pkg::WGT_W-1:0] & WMASK;
  assign wb    = in_data[wjd_pkg::IN_DATA_W-1:wjd_pkg::WGT_W] & WMASK;
  assign hit_i = (wa != '0) && (wa == wb);
  assign hit_d = (wa == '0) != (wb == '0);

  assign sum_i = {1'b0, intersect_acc} + wjd_pkg::SUM_W'(wa);
  assign sum_d = {1'b0, distinct_acc} + wjd_pkg::SUM_W'(wa | wb);

  always_comb begin
    i_new = intersect_acc;
    d_new = distinct_acc;
    if (hit_i) begin
      i_new = sum_i[wjd_pkg::ACC_W] ? wjd_pkg::ACC_MAX : sum_i[wjd_pkg::ACC_W-1:0];
    end
    if (hit_d) begin
      d_new = sum_d[wjd_pkg::ACC_W] ? wjd_pkg::ACC_MAX : sum_d[wjd_pkg::ACC_W-1:0];
    end
  end

  assign cnt_new = (column_count == wjd_pkg::CNT_MAX) ? column_count : column_count + 1'b1;

  // restoring divide of D*2^16 by I+D; D <= I+D so the first step is unshifted
  assign rem_sh  = cmd.div_first ? div_rem : {div_rem[wjd_pkg::REM_W-2:0], 1'b0};
  assign q_bit   = (rem_sh >= {1'b0, div_den});
  assign rem_sub = rem_sh - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns   <= NUM_COLUMNS_RST;
      intersect_acc <= '0;
      distinct_acc  <= '0;
      column_count  <= '0;
    end else begin
      if (cfg_we) begin
        num_columns <= cfg_wdata;
      end
      if (cmd.acc_en) begin
        if (cmd.snap) begin
          intersect_acc <= '0;
          distinct_acc  <= '0;
          column_count  <= '0;
        end else begin
          intersect_acc <= i_new;
          distinct_acc  <= d_new;
          column_count  <= cnt_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      res_i     <= i_new;
      res_d     <= d_new;
      res_empty <= (i_new == '0) && (d_new == '0);
      res_err   <= (cnt_new != num_columns);
      div_den   <= {1'b0, i_new} + {1'b0, d_new};
      div_rem   <= {2'b00, d_new};
      div_q     <= '0;
    end else if (cmd.div_step) begin
      div_rem <= q_bit ? rem_sub : rem_sh;
      div_q   <= {div_q[wjd_pkg::DIST_W-2:0], q_bit};
    end
    if (cmd.out_load) begin
      out_data <= {(wjd_pkg::OUT_DATA_W - wjd_pkg::OUT_BITS)'(0), res_d, res_i,
                   res_empty ? wjd_pkg::Q_ONE : div_q};
      out_user <= {res_err, res_empty};
    end
  end

endmodule

>>> src/weighted_jaccard_distance.sv
// Top level of the weighted Jaccard distance block.
//
// Slave stream: one column per transfer, s_tdata = {attr_b, attr_a}, s_tlast
// marks the final column of a vector pair. Columns are taken one per cycle.
// Master stream: one transfer per vector pair, m_tdata = {distinct_total,
// intersect_total, distance} with distance in Q1.16 (65536 = 1.0), and
// m_tuser = {length_error, empty_res}.
// cfg_we/cfg_wdata write the expected column count (reset: MAX_COLUMNS).
// After the last column is accepted the input stalls while the distance is
// formed by a 17-step shift-subtract divider, one quotient bit per cycle; the
// result then passes through a holding state into the output register; m_tvalid
// is set in the same cycle that s_tready returns high. If the receiver stalls,
// the finished result waits in the holding state until the output register
// frees; s_tready stays low meanwhile.
// Synchronous reset clears the sums, column count and output valid.
module weighted_jaccard_distance #(
  parameter int MAX_COLUMNS = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wjd_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wjd_pkg::IN_DATA_W-1:0]     s_tdata,  // attr_a, attr_b
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wjd_pkg::OUT_DATA_W-1:0]    m_tdata,  // distance, intersect_total, distinct_total
  output logic [wjd_pkg::OUT_USER_W-1:0]    m_tuser   // empty_res, length_error
);

  wjd_pkg::cmd_t cmd;

  wjd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  wjd_dpath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

>>> src/wjd_checker.sv
// Port-level checks for the weighted Jaccard distance block, with bind.
module wjd_port_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tlast,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [wjd_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic [wjd_pkg::OUT_USER_W-1:0]    m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped or changed while stalled");

  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("column taken while the divider runs");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[wjd_pkg::DIST_W-1:0] <= wjd_pkg::Q_ONE)
    else $error("distance above 1.0");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[wjd_pkg::DIST_W-1:0] == wjd_pkg::Q_ONE &&
      m_tdata[wjd_pkg::OUT_BITS-1:wjd_pkg::DIST_W] == '0)
    else $error("empty flag with nonzero sums or wrong distance");

endmodule

bind weighted_jaccard_distance wjd_port_checker u_wjd_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
